[src/tseq_pkg.sv]
// ----------------------------------------------------------------------------
// tseq_pkg
// shared widths, codes and controller/datapath handoff types for the
// timestamp sorted event queue
// ----------------------------------------------------------------------------
package tseq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int TIME_W    = 16;
    localparam int PAY_W     = 48;
    localparam int MODE_W    = 3;
    localparam int KIND_W    = 2;
    localparam int FILL_W    = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BELOW  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ABOVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHIFT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        K_DONE  = 2'd0,
        K_MOVED = 2'd1,
        K_DROP  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        S_INS_RD, S_INS_EV,
        S_MB_RD, S_MB_EV, S_MB_DONE,
        S_MA_CHK, S_MA_RD, S_MA_EV,
        S_EM_RD, S_EM_EV,
        S_CP_RD, S_CP_EV,
        S_SH_RD, S_SH_EV,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {RS_IDX, RS_IDXPOS, RS_LAST} t_rsel;
    typedef enum logic [1:0] {WS_CARRY, WS_SHIFT, WS_COPY} t_wsel;
    typedef enum logic [2:0] {C_HOLD, C_INC, C_SUB_IDX, C_SET_IDX, C_ZERO} t_cop;

    typedef struct packed {
        logic   load;
        logic   rd_en;
        t_rsel  rsel;
        logic   wr_en;
        t_wsel  wsel;
        logic   carry_ld;
        logic   found_set;
        logic   idx_inc;
        logic   idx_clr;
        logic   pos_ld;
        logic   end_ld_idx;
        logic   end_ld_cnt;
        t_cop   cop;
        logic   out_ld;
        t_kind  kind;
        logic   out_move;
        logic   out_last;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic idx_eq_cnt;
        logic idx_zero;
        logic full;
        logic cnt_zero;
        logic found;
        logic gt_t;
        logic lt_b;
        logic idx_last;
        logic out_free;
    } t_sts;

endpackage

[src/tseq_if.sv]
// ----------------------------------------------------------------------------
// tseq interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface tseq_in_if;
    logic                          valid;
    logic                          ready;
    logic [tseq_pkg::MODE_W-1:0]   mode;
    logic [tseq_pkg::TIME_W-1:0]   event_time;
    logic [tseq_pkg::PAY_W-1:0]    event_payload;
    logic [tseq_pkg::TIME_W-1:0]   time_bound;
    logic signed [tseq_pkg::TIME_W-1:0] time_shift;

    modport source (output valid, mode, event_time, event_payload, time_bound,
                    time_shift, input ready);
    modport sink   (input valid, mode, event_time, event_payload, time_bound,
                    time_shift, output ready);
endinterface

interface tseq_out_if;
    logic                          valid;
    logic                          ready;
    logic [tseq_pkg::KIND_W-1:0]   result_kind;
    logic [tseq_pkg::TIME_W-1:0]   out_time;
    logic [tseq_pkg::PAY_W-1:0]    out_payload;
    logic [tseq_pkg::FILL_W-1:0]   fill_count;
    logic                          last_of_run;

    modport source (output valid, result_kind, out_time, out_payload, fill_count,
                    last_of_run, input ready);
    modport sink   (input valid, result_kind, out_time, out_payload, fill_count,
                    last_of_run, output ready);
endinterface

[src/timestamp_sorted_event_queue_top.sv]
// ----------------------------------------------------------------------------
// timestamp_sorted_event_queue_top
// sorted event store with insert, bounded moves, time shift and clear
//
//   channel  dir  contents
//   i_evt    in   mode, event_time, event_payload, time_bound, time_shift
//   o_res    out  result_kind, out_time, out_payload, fill_count, last_of_run
//
// one item at a time; the entry memory has one read and one write port and
// each visited entry is first read, then acted on
// reset clears the fill count, index, found flag, result valid and state; no memory sweep
// a stalled result holds the sequencer until it is taken
// ----------------------------------------------------------------------------
module timestamp_sorted_event_queue_top #(
    parameter int DEPTH = tseq_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tseq_in_if.sink     i_evt,
    tseq_out_if.source  o_res
);
    tseq_pkg::t_cmd cmd;
    tseq_pkg::t_sts sts;

    tseq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_evt.valid),
        .o_ready (i_evt.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tseq_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_evt   (i_evt),
        .o_res   (o_res)
    );

endmodule

[src/tseq_dp.sv]
// ----------------------------------------------------------------------------
// tseq_dp
// entry memory, index/count registers, compares and result register
// ----------------------------------------------------------------------------
module tseq_dp #(
    parameter int DEPTH = tseq_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tseq_pkg::t_cmd   i_cmd,
    output tseq_pkg::t_sts   o_sts,
    tseq_in_if.sink          i_evt,
    tseq_out_if.source       o_res
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = tseq_pkg::TIME_W;
    localparam int PW = tseq_pkg::PAY_W;

    logic [TW-1:0] r_mem_t [DEPTH];
    logic [PW-1:0] r_mem_p [DEPTH];

    logic [TW-1:0] r_rd_t;
    logic [PW-1:0] r_rd_p;
    logic [tseq_pkg::MODE_W-1:0] r_mode;
    logic [TW-1:0] r_time, r_bound, r_delta;
    logic [TW-1:0] r_carry_t;
    logic [PW-1:0] r_carry_p;
    logic          r_found;
    logic [CW-1:0] r_cnt, r_idx, r_pos, r_end;

    logic          r_ov;
    logic [tseq_pkg::KIND_W-1:0] r_okind;
    logic [TW-1:0] r_otime;
    logic [PW-1:0] r_opay;
    logic [tseq_pkg::FILL_W-1:0] r_ofill;
    logic          r_olast;

    logic [CW-1:0] rd_addr, idx_pos, idx_p1;
    logic [AW-1:0] wr_addr;
    logic [TW-1:0] wr_t;
    logic [PW-1:0] wr_p;
    logic [CW-1:0] n_cnt;

    assign idx_pos = r_idx + r_pos;
    assign idx_p1  = r_idx + CW'(1);
    assign wr_addr = r_idx[AW-1:0];

    always_comb begin
        case (i_cmd.rsel)
            tseq_pkg::RS_IDXPOS: rd_addr = idx_pos;
            tseq_pkg::RS_LAST:   rd_addr = r_cnt - CW'(1);
            default:             rd_addr = r_idx;
        endcase
        case (i_cmd.wsel)
            tseq_pkg::WS_SHIFT: begin
                wr_t = r_rd_t - r_delta;
                wr_p = r_rd_p;
            end
            tseq_pkg::WS_COPY: begin
                wr_t = r_rd_t;
                wr_p = r_rd_p;
            end
            default: begin
                wr_t = r_carry_t;
                wr_p = r_carry_p;
            end
        endcase
        case (i_cmd.cop)
            tseq_pkg::C_INC:     n_cnt = r_cnt + CW'(1);
            tseq_pkg::C_SUB_IDX: n_cnt = r_cnt - r_idx;
            tseq_pkg::C_SET_IDX: n_cnt = r_idx;
            tseq_pkg::C_ZERO:    n_cnt = '0;
            default:             n_cnt = r_cnt;
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem_t[wr_addr] <= wr_t;
            r_mem_p[wr_addr] <= wr_p;
        end
        if (i_cmd.rd_en) begin
            r_rd_t <= r_mem_t[rd_addr[AW-1:0]];
            r_rd_p <= r_mem_p[rd_addr[AW-1:0]];
        end
    end

    // request latch and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_evt.mode;
            r_time    <= i_evt.event_time;
            r_bound   <= i_evt.time_bound;
            r_delta   <= i_evt.time_shift;
            r_carry_t <= i_evt.event_time;
            r_carry_p <= i_evt.event_payload;
        end else if (i_cmd.carry_ld) begin
            r_carry_t <= r_rd_t;
            r_carry_p <= r_rd_p;
        end
        if (i_cmd.pos_ld) begin
            r_pos <= r_idx;
        end
        if (i_cmd.end_ld_idx) begin
            r_end <= r_idx;
        end else if (i_cmd.end_ld_cnt) begin
            r_end <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.load || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_p1;
            end
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (i_cmd.found_set) begin
                r_found <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_okind <= i_cmd.kind;
            r_otime <= i_cmd.out_move ? r_rd_t : '0;
            r_opay  <= i_cmd.out_move ? r_rd_p : '0;
            r_ofill <= tseq_pkg::FILL_W'(n_cnt);
            r_olast <= i_cmd.out_last;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.result_kind = r_okind;
    assign o_res.out_time    = r_otime;
    assign o_res.out_payload = r_opay;
    assign o_res.fill_count  = r_ofill;
    assign o_res.last_of_run = r_olast;

    assign o_sts.mode       = r_mode;
    assign o_sts.idx_eq_cnt = (r_idx == r_cnt);
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.full       = (r_cnt == CW'(DEPTH));
    assign o_sts.cnt_zero   = (r_cnt == '0);
    assign o_sts.found      = r_found;
    assign o_sts.gt_t       = (r_rd_t > r_time);
    assign o_sts.lt_b       = (r_rd_t < r_bound);
    assign o_sts.idx_last   = (idx_p1 == r_end);
    assign o_sts.out_free   = !r_ov || o_res.ready;

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above depth");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cop == tseq_pkg::C_INC |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("insert did not grow count by one");
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> r_idx <= r_cnt && r_idx < CW'(DEPTH))
        else $error("write outside stored range");
    a_out_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> (!r_ov || o_res.ready))
        else $error("result register overwritten");

endmodule

[src/tseq_ctrl.sv]
// ----------------------------------------------------------------------------
// tseq_ctrl
// operation sequencer driving the queue datapath
// ----------------------------------------------------------------------------
module tseq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tseq_pkg::t_sts   i_sts,
    output tseq_pkg::t_cmd   o_cmd
);
    tseq_pkg::t_state r_state, n_state;
    tseq_pkg::t_kind  r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tseq_pkg::S_IDLE;
            r_kind  <= tseq_pkg::K_DONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            tseq_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tseq_pkg::S_DISP;
                end
            end
            tseq_pkg::S_DISP: begin
                case (i_sts.mode)
                    tseq_pkg::MODE_INSERT: begin
                        if (i_sts.full) begin
                            n_kind  = tseq_pkg::K_DROP;
                            n_state = tseq_pkg::S_RESP;
                        end else begin
                            n_state = tseq_pkg::S_INS_RD;
                        end
                    end
                    tseq_pkg::MODE_BELOW: n_state = tseq_pkg::S_MB_RD;
                    tseq_pkg::MODE_ABOVE: begin
                        if (i_sts.cnt_zero) begin
                            n_kind  = tseq_pkg::K_NONE;
                            n_state = tseq_pkg::S_RESP;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.rsel  = tseq_pkg::RS_LAST;
                            n_state     = tseq_pkg::S_MA_CHK;
                        end
                    end
                    tseq_pkg::MODE_SHIFT: n_state = tseq_pkg::S_SH_RD;
                    tseq_pkg::MODE_CLEAR: begin
                        o_cmd.cop = tseq_pkg::C_ZERO;
                        n_kind    = tseq_pkg::K_DONE;
                        n_state   = tseq_pkg::S_RESP;
                    end
                    default: begin
                        n_kind  = tseq_pkg::K_DONE;
                        n_state = tseq_pkg::S_RESP;
                    end
                endcase
            end
            tseq_pkg::S_INS_RD: begin
                if (i_sts.idx_eq_cnt) begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.wsel  = tseq_pkg::WS_CARRY;
                    o_cmd.cop   = tseq_pkg::C_INC;
                    n_kind      = tseq_pkg::K_DONE;
                    n_state     = tseq_pkg::S_RESP;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = tseq_pkg::S_INS_EV;
                end
            end
            tseq_pkg::S_INS_EV: begin
                if (i_sts.found || i_sts.gt_t) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wsel      = tseq_pkg::WS_CARRY;
                    o_cmd.carry_ld  = 1'b1;
                    o_cmd.found_set = 1'b1;
                end
                o_cmd.idx_inc = 1'b1;
                n_state       = tseq_pkg::S_INS_RD;
            end
            tseq_pkg::S_MB_RD: begin
                if (i_sts.idx_eq_cnt) begin
                    n_state = tseq_pkg::S_MB_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = tseq_pkg::S_MB_EV;
                end
            end
            tseq_pkg::S_MB_EV: begin
                if (i_sts.lt_b) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = tseq_pkg::S_MB_RD;
                end else begin
                    n_state = tseq_pkg::S_MB_DONE;
                end
            end
            tseq_pkg::S_MB_DONE: begin
                if (i_sts.idx_zero) begin
                    n_kind  = tseq_pkg::K_NONE;
                    n_state = tseq_pkg::S_RESP;
                end else begin
                    o_cmd.pos_ld     = 1'b1;
                    o_cmd.end_ld_idx = 1'b1;
                    o_cmd.cop        = tseq_pkg::C_SUB_IDX;
                    o_cmd.idx_clr    = 1'b1;
                    n_state          = tseq_pkg::S_EM_RD;
                end
            end
            tseq_pkg::S_MA_CHK: begin
                if (i_sts.lt_b) begin
                    n_kind  = tseq_pkg::K_NONE;
                    n_state = tseq_pkg::S_RESP;
                end else begin
                    n_state = tseq_pkg::S_MA_RD;
                end
            end
            tseq_pkg::S_MA_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = tseq_pkg::S_MA_EV;
            end
            tseq_pkg::S_MA_EV: begin
                if (!i_sts.lt_b) begin
                    o_cmd.end_ld_cnt = 1'b1;
                    o_cmd.cop        = tseq_pkg::C_SET_IDX;
                    n_state          = tseq_pkg::S_EM_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = tseq_pkg::S_MA_RD;
                end
            end
            tseq_pkg::S_EM_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = tseq_pkg::S_EM_EV;
            end
            tseq_pkg::S_EM_EV: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.kind     = tseq_pkg::K_MOVED;
                    o_cmd.out_move = 1'b1;
                    o_cmd.out_last = i_sts.idx_last;
                    o_cmd.idx_inc  = 1'b1;
                    if (!i_sts.idx_last) begin
                        n_state = tseq_pkg::S_EM_RD;
                    end else if (i_sts.mode == tseq_pkg::MODE_BELOW) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = tseq_pkg::S_CP_RD;
                    end else begin
                        n_state = tseq_pkg::S_IDLE;
                    end
                end
            end
            tseq_pkg::S_CP_RD: begin
                if (i_sts.idx_eq_cnt) begin
                    n_state = tseq_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rsel  = tseq_pkg::RS_IDXPOS;
                    n_state     = tseq_pkg::S_CP_EV;
                end
            end
            tseq_pkg::S_CP_EV: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wsel    = tseq_pkg::WS_COPY;
                o_cmd.idx_inc = 1'b1;
                n_state       = tseq_pkg::S_CP_RD;
            end
            tseq_pkg::S_SH_RD: begin
                if (i_sts.idx_eq_cnt) begin
                    n_kind  = tseq_pkg::K_DONE;
                    n_state = tseq_pkg::S_RESP;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = tseq_pkg::S_SH_EV;
                end
            end
            tseq_pkg::S_SH_EV: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wsel    = tseq_pkg::WS_SHIFT;
                o_cmd.idx_inc = 1'b1;
                n_state       = tseq_pkg::S_SH_RD;
            end
            tseq_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.kind     = r_kind;
                    o_cmd.out_last = 1'b1;
                    n_state        = tseq_pkg::S_IDLE;
                end
            end
            default: n_state = tseq_pkg::S_IDLE;
        endcase
    end

    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == tseq_pkg::S_DISP)
        else $error("request not dispatched");
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.out_ld && o_cmd.load))
        else $error("result issued while taking a request");

endmodule

[tb/sv/timestamp_sorted_event_queue_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_sorted_event_queue_top_tb
// drives insert, move, shift, clear and unused mode items with random gaps on
// both sides, predicts every result from a behavioral copy of the sorted store
// and compares each result item field by field in order
// ----------------------------------------------------------------------------
module timestamp_sorted_event_queue_top_tb;

    localparam int QDEPTH = tseq_pkg::DEPTH_DEF;

    typedef struct packed {
        logic [tseq_pkg::KIND_W-1:0] kind;
        logic [tseq_pkg::TIME_W-1:0] tm;
        logic [tseq_pkg::PAY_W-1:0]  pay;
        logic [tseq_pkg::FILL_W-1:0] fill;
        logic                        last;
    } t_res;

    logic i_clk;
    logic i_rst_n;
    tseq_in_if  evt_if ();
    tseq_out_if res_if ();

    timestamp_sorted_event_queue_top #(.DEPTH(QDEPTH)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_evt  (evt_if.sink),
        .o_res  (res_if.source)
    );

    logic [tseq_pkg::TIME_W-1:0] store_time [QDEPTH];
    logic [tseq_pkg::PAY_W-1:0]  store_pay  [QDEPTH];
    int                store_cnt;
    t_res              pending_results [$];
    int                fail_cnt;
    int                item_cnt;
    int                res_cnt;
    int                cycle_cnt;
    logic              busy_sink;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at result %0d", what, got, exp, res_cnt);
        fail_cnt++;
    endtask

    function automatic t_res mk(input logic [tseq_pkg::KIND_W-1:0] k,
                                input logic [tseq_pkg::TIME_W-1:0] t,
                                input logic [tseq_pkg::PAY_W-1:0] p);
        t_res r;
        r = '0;
        r.kind = k;
        r.tm = t;
        r.pay = p;
        return r;
    endfunction

    task automatic predict_queue(input logic [tseq_pkg::MODE_W-1:0] mode,
                                 input logic [tseq_pkg::TIME_W-1:0] t,
                                 input logic [tseq_pkg::PAY_W-1:0] p,
                                 input logic [tseq_pkg::TIME_W-1:0] bound,
                                 input logic [tseq_pkg::TIME_W-1:0] delta);
        t_res outs [$];
        int pos;
        int moved;
        outs = {};
        case (mode)
            tseq_pkg::MODE_INSERT: begin
                if (store_cnt >= QDEPTH) begin
                    outs.push_back(mk(tseq_pkg::K_DROP, '0, '0));
                end else begin
                    pos = store_cnt;
                    for (int i = 0; i < store_cnt; i++)
                        if (store_time[i] > t) begin
                            pos = i;
                            break;
                        end
                    for (int i = store_cnt; i > pos; i--) begin
                        store_time[i] = store_time[i-1];
                        store_pay[i] = store_pay[i-1];
                    end
                    store_time[pos] = t;
                    store_pay[pos] = p;
                    store_cnt++;
                    outs.push_back(mk(tseq_pkg::K_DONE, '0, '0));
                end
            end
            tseq_pkg::MODE_BELOW: begin
                moved = 0;
                while (moved < store_cnt && store_time[moved] < bound) begin
                    outs.push_back(mk(tseq_pkg::K_MOVED, store_time[moved], store_pay[moved]));
                    moved++;
                end
                if (moved == 0) begin
                    outs.push_back(mk(tseq_pkg::K_NONE, '0, '0));
                end else begin
                    for (int i = 0; i + moved < store_cnt; i++) begin
                        store_time[i] = store_time[i+moved];
                        store_pay[i] = store_pay[i+moved];
                    end
                    store_cnt -= moved;
                    for (int i = store_cnt; i < QDEPTH; i++) begin
                        store_time[i] = '0;
                        store_pay[i] = '0;
                    end
                end
            end
            tseq_pkg::MODE_ABOVE: begin
                pos = store_cnt;
                if (store_cnt > 0 && store_time[store_cnt-1] >= bound)
                    for (int i = 0; i < store_cnt; i++)
                        if (store_time[i] >= bound) begin
                            pos = i;
                            break;
                        end
                if (pos >= store_cnt) begin
                    outs.push_back(mk(tseq_pkg::K_NONE, '0, '0));
                end else begin
                    for (int i = pos; i < store_cnt; i++)
                        outs.push_back(mk(tseq_pkg::K_MOVED, store_time[i], store_pay[i]));
                    store_cnt = pos;
                    for (int i = pos; i < QDEPTH; i++) begin
                        store_time[i] = '0;
                        store_pay[i] = '0;
                    end
                end
            end
            tseq_pkg::MODE_SHIFT: begin
                for (int i = 0; i < store_cnt; i++)
                    store_time[i] = store_time[i] - delta;
                outs.push_back(mk(tseq_pkg::K_DONE, '0, '0));
            end
            tseq_pkg::MODE_CLEAR: begin
                store_cnt = 0;
                for (int i = 0; i < QDEPTH; i++) begin
                    store_time[i] = '0;
                    store_pay[i] = '0;
                end
                outs.push_back(mk(tseq_pkg::K_DONE, '0, '0));
            end
            default: outs.push_back(mk(tseq_pkg::K_DONE, '0, '0));
        endcase
        foreach (outs[k]) begin
            outs[k].fill = store_cnt[tseq_pkg::FILL_W-1:0];
            outs[k].last = (k == outs.size() - 1);
            pending_results.push_back(outs[k]);
        end
    endtask

    task automatic send_item(input logic [tseq_pkg::MODE_W-1:0] mode,
                             input logic [tseq_pkg::TIME_W-1:0] t,
                             input logic [tseq_pkg::PAY_W-1:0] p,
                             input logic [tseq_pkg::TIME_W-1:0] bound,
                             input logic [tseq_pkg::TIME_W-1:0] delta);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.mode <= mode;
        evt_if.event_time <= t;
        evt_if.event_payload <= p;
        evt_if.time_bound <= bound;
        evt_if.time_shift <= delta;
        do @(posedge i_clk); while (!evt_if.ready);
        predict_queue(mode, t, p, bound, delta);
        item_cnt++;
    endtask

    function automatic logic [tseq_pkg::PAY_W-1:0] rnd_pay();
        return tseq_pkg::PAY_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [tseq_pkg::TIME_W-1:0] rnd_time();
        return tseq_pkg::TIME_W'($urandom());
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // result side: random stall per result, check against oldest expectation
    initial begin
        t_res e;
        int stall;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = busy_sink ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            res_cnt++;
            if (pending_results.size() == 0) begin
                report("unexpected result", 64'(res_if.result_kind), '0);
            end else begin
                e = pending_results.pop_front();
                if (res_if.result_kind !== e.kind)
                    report("result_kind", 64'(res_if.result_kind), 64'(e.kind));
                if (res_if.out_time !== e.tm)
                    report("out_time", 64'(res_if.out_time), 64'(e.tm));
                if (res_if.out_payload !== e.pay)
                    report("out_payload", 64'(res_if.out_payload), 64'(e.pay));
                if (res_if.fill_count !== e.fill)
                    report("fill_count", 64'(res_if.fill_count), 64'(e.fill));
                if (res_if.last_of_run !== e.last)
                    report("last_of_run", 64'(res_if.last_of_run), 64'(e.last));
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > 2000000) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("FAIL timestamp_sorted_event_queue_top");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_item(tseq_pkg::MODE_BELOW, '0, '0, 16'hFFFF, '0);
        send_item(tseq_pkg::MODE_ABOVE, '0, '0, '0, '0);
        send_item(tseq_pkg::MODE_INSERT, 16'hFFFF, {tseq_pkg::PAY_W{1'b1}}, '0, '0);
        send_item(tseq_pkg::MODE_INSERT, '0, '0, '0, '0);
        send_item(tseq_pkg::MODE_INSERT, 16'd100, 48'h123456789ABC, '0, '0);
        send_item(tseq_pkg::MODE_INSERT, 16'd100, 48'hA5A5A5A5A5A5, '0, '0);
        send_item(tseq_pkg::MODE_BELOW, '0, '0, '0, '0);
        send_item(tseq_pkg::MODE_BELOW, '0, '0, 16'd101, '0);
        send_item(tseq_pkg::MODE_SHIFT, '0, '0, '0, 16'h8000);
        send_item(tseq_pkg::MODE_SHIFT, '0, '0, '0, 16'h7FFF);
        send_item(tseq_pkg::MODE_INSERT, 16'd10, 48'h5A5A5A5A5A5A, '0, '0);
        send_item(tseq_pkg::MODE_SHIFT, '0, '0, '0, 16'h0020);
        send_item(tseq_pkg::MODE_ABOVE, '0, '0, 16'hFFFF, '0);
        send_item(tseq_pkg::MODE_ABOVE, '0, '0, 16'h8000, '0);
        send_item(3'd5, 16'hFFFF, {tseq_pkg::PAY_W{1'b1}}, 16'hFFFF, 16'hFFFF);
        send_item(3'd6, '0, '0, '0, '0);
        send_item(3'd7, '0, '0, '0, '0);
        send_item(tseq_pkg::MODE_CLEAR, '0, '0, '0, '0);
        send_item(tseq_pkg::MODE_ABOVE, '0, '0, '0, '0);
    endtask

    task automatic test_fill_to_full();
        for (int i = 0; i < QDEPTH + 2; i++)
            send_item(tseq_pkg::MODE_INSERT, tseq_pkg::TIME_W'($urandom_range(0, 300)),
                      rnd_pay(), '0, '0);
        send_item(tseq_pkg::MODE_ABOVE, '0, '0, '0, '0);
    endtask

    task automatic test_random();
        int r;
        for (int i = 0; i < 280; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_item(tseq_pkg::MODE_INSERT,
                          (r < 45) ? tseq_pkg::TIME_W'($urandom_range(0, 500)) : rnd_time(),
                          rnd_pay(), rnd_time(), rnd_time());
            else if (r < 70)
                send_item(tseq_pkg::MODE_BELOW, rnd_time(), rnd_pay(),
                          tseq_pkg::TIME_W'($urandom_range(0, 600)), rnd_time());
            else if (r < 82)
                send_item(tseq_pkg::MODE_ABOVE, rnd_time(), rnd_pay(),
                          tseq_pkg::TIME_W'($urandom_range(0, 600)), rnd_time());
            else if (r < 92)
                send_item(tseq_pkg::MODE_SHIFT, rnd_time(), rnd_pay(), rnd_time(),
                          (r < 88) ? tseq_pkg::TIME_W'($urandom_range(0, 40) - 20)
                                   : rnd_time());
            else if (r < 96)
                send_item(tseq_pkg::MODE_CLEAR, rnd_time(), rnd_pay(), rnd_time(), rnd_time());
            else
                send_item(tseq_pkg::MODE_W'($urandom_range(5, 7)), rnd_time(), rnd_pay(),
                          rnd_time(), rnd_time());
        end
    endtask

    initial begin
        fail_cnt = 0;
        item_cnt = 0;
        res_cnt = 0;
        busy_sink = 1'b1;
        store_cnt = 0;
        for (int i = 0; i < QDEPTH; i++) begin
            store_time[i] = '0;
            store_pay[i] = '0;
        end
        i_rst_n = 1'b0;
        evt_if.valid = 1'b0;
        evt_if.mode = '0;
        evt_if.event_time = '0;
        evt_if.event_payload = '0;
        evt_if.time_bound = '0;
        evt_if.time_shift = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_to_full();
        test_random();
        busy_sink = 1'b0;
        send_item(tseq_pkg::MODE_CLEAR, '0, '0, '0, '0);
        evt_if.valid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (pending_results.size() != 0)
            report("results left over", 64'(pending_results.size()), '0);
        $display("covered %0d request items and %0d result items", item_cnt, res_cnt);
        $display("insert to full, drops, moves by bound, wrapping shifts, clears, unused modes");
        if (fail_cnt == 0)
            $display("PASS timestamp_sorted_event_queue_top");
        else
            $display("FAIL timestamp_sorted_event_queue_top");
        $finish;
    end
endmodule
